/* hdl/csvlp_pkg.sv */
// ----------------------------------------------------------------------------
// csvlp_pkg
// Shared types and constants of the CSV sample line parser with sample FIFO.
// ----------------------------------------------------------------------------
package csvlp_pkg;

  localparam int unsigned FifoDepthDefault = 64;
  localparam int unsigned LineBytesDefault = 64;

  localparam int unsigned SampleW = 16;
  localparam int unsigned StatusW = 8;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharVt    = 8'h0B;
  localparam logic [7:0] CharFf    = 8'h0C;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic KindByte = 1'b0;
  localparam logic KindPop  = 1'b1;

  typedef enum logic [2:0] {
    LineBeforeFirst  = 3'd0,
    LineFirstToken   = 3'd1,
    LineBeforeSecond = 3'd2,
    LineSecondToken  = 3'd3,
    LineRest         = 3'd4
  } line_stage_e;

  typedef enum logic [1:0] {
    NumBlank  = 2'd0,
    NumDigits = 2'd1,
    NumDone   = 2'd2
  } number_stage_e;

  typedef enum logic [1:0] {
    LinkConnected    = 2'd0,
    LinkCheckLeads   = 2'd1,
    LinkDisconnected = 2'd2
  } link_status_e;

endpackage

/* hdl/csv_sample_line_parser_fifo.sv */
// ----------------------------------------------------------------------------
// csv_sample_line_parser_fifo
// Parses "sample,status" text lines byte by byte and queues the samples.
// ----------------------------------------------------------------------------
// Each input transaction is either one received byte or one pop request. The
// block takes one transaction per clock cycle while the output side keeps
// up: the parser and the FIFO pointers live in flip-flops and settle in the
// accepting cycle, while the samples sit in a RAM with a registered read.
// Every transaction yields exactly one result transaction, through the RAM
// read stage and then the output register. Those two stages form a two-entry
// buffer, so one more transaction is accepted while a result waits to be
// taken; after that the input stalls. Lines end on CR or LF; commas collapse,
// blanks and one sign may lead a token, NUL ends the text, and only the first
// LINE_BYTES-1 bytes of a line count. A completed line with a first token
// pushes its 16-bit sample; a full FIFO drops its oldest entry. A second
// token sets link_status (0 connected, 1 check leads, else disconnected).
// A pop returns the oldest sample, or the last popped one if the FIFO is
// empty. The sample RAM needs no clearing after reset: only written entries
// are ever read.
// ----------------------------------------------------------------------------
module csv_sample_line_parser_fifo #(
  parameter int unsigned FIFO_DEPTH = csvlp_pkg::FifoDepthDefault,
  parameter int unsigned LINE_BYTES = csvlp_pkg::LineBytesDefault,
  parameter int unsigned CntW       = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [csvlp_pkg::SampleW-1:0] sample_out_o,
  output logic                          has_sample_o,
  output logic [1:0]                    link_status_o,
  output logic [CntW-1:0]               sample_count_o
);

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned LenW = $clog2(LINE_BYTES);
  localparam logic [LenW-1:0] LenMax = LenW'(LINE_BYTES - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam int unsigned SW = csvlp_pkg::SampleW;
  localparam int unsigned TW = csvlp_pkg::StatusW;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  // Parser state
  csvlp_pkg::line_stage_e   line_stage_q, line_stage_d;
  csvlp_pkg::number_stage_e num_stage_q, num_stage_d;
  logic [SW-1:0]   sample_acc_q, sample_acc_d;
  logic [TW-1:0]   status_acc_q, status_acc_d;
  logic            sample_neg_q, sample_neg_d;
  logic            status_neg_q, status_neg_d;
  logic            first_seen_q, first_seen_d;
  logic            second_seen_q, second_seen_d;
  logic            text_ended_q, text_ended_d;
  logic [LenW-1:0] line_len_q, line_len_d;

  // FIFO control
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      status_q, status_d;

  // Read stage and output register
  logic            s1_valid_q;
  logic            s1_pop_q;
  logic [CntW-1:0] s1_count_q;
  logic [1:0]      s1_status_q;
  logic            out_valid_q;
  logic [SW-1:0]   out_sample_q;
  logic [CntW-1:0] out_count_q;
  logic [1:0]      out_status_q;
  logic [SW-1:0]   last_sample_q;

  logic          in_accept, byte_ev, pop_ev, pop_hit;
  logic          s1_move;
  logic          push;
  logic [SW-1:0] push_val;
  logic [SW-1:0] ram_rdata;
  logic [SW-1:0] s1_sample;

  // Byte classification for the number scanner
  logic          is_blank, is_digit, is_sign;
  logic [3:0]    digit;
  logic          feed_second;
  csvlp_pkg::number_stage_e feed_stage;
  logic [TW-1:0] status_val;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_accept  = in_valid_i && in_ready_o;
  assign byte_ev    = in_accept && (kind_i == csvlp_pkg::KindByte);
  assign pop_ev     = in_accept && (kind_i == csvlp_pkg::KindPop);
  assign pop_hit    = pop_ev && (count_q != '0);

  assign is_blank = (rx_byte_i == csvlp_pkg::CharSpace) || (rx_byte_i == csvlp_pkg::CharTab) ||
                    (rx_byte_i == csvlp_pkg::CharVt)    || (rx_byte_i == csvlp_pkg::CharFf);
  assign is_digit = (rx_byte_i >= csvlp_pkg::CharZero) && (rx_byte_i <= csvlp_pkg::CharNine);
  assign is_sign  = (rx_byte_i == csvlp_pkg::CharPlus) || (rx_byte_i == csvlp_pkg::CharMinus);
  assign digit    = rx_byte_i[3:0];

  // A token start always rescans from the blank-skipping stage.
  assign feed_second = (line_stage_q == csvlp_pkg::LineBeforeSecond) ||
                       (line_stage_q == csvlp_pkg::LineSecondToken);
  assign feed_stage  = ((line_stage_q == csvlp_pkg::LineBeforeFirst) ||
                        (line_stage_q == csvlp_pkg::LineBeforeSecond)) ?
                       csvlp_pkg::NumBlank : num_stage_q;

  assign push_val   = sample_neg_q ? (SW'(0) - sample_acc_q) : sample_acc_q;
  assign status_val = status_neg_q ? (TW'(0) - status_acc_q) : status_acc_q;

  always_comb begin
    line_stage_d  = line_stage_q;
    num_stage_d   = num_stage_q;
    sample_acc_d  = sample_acc_q;
    status_acc_d  = status_acc_q;
    sample_neg_d  = sample_neg_q;
    status_neg_d  = status_neg_q;
    first_seen_d  = first_seen_q;
    second_seen_d = second_seen_q;
    text_ended_d  = text_ended_q;
    line_len_d    = line_len_q;
    status_d      = status_q;
    push          = 1'b0;

    if (byte_ev) begin
      if ((rx_byte_i == csvlp_pkg::CharCr) || (rx_byte_i == csvlp_pkg::CharLf)) begin
        // Line end: push a seen sample, update a seen status, clear the line.
        if ((line_len_q != '0) && first_seen_q) begin
          push = 1'b1;
          if (second_seen_q) begin
            if (status_val == TW'(0)) begin
              status_d = csvlp_pkg::LinkConnected;
            end else if (status_val == TW'(1)) begin
              status_d = csvlp_pkg::LinkCheckLeads;
            end else begin
              status_d = csvlp_pkg::LinkDisconnected;
            end
          end
        end
        line_stage_d  = csvlp_pkg::LineBeforeFirst;
        num_stage_d   = csvlp_pkg::NumBlank;
        sample_acc_d  = '0;
        status_acc_d  = '0;
        sample_neg_d  = 1'b0;
        status_neg_d  = 1'b0;
        first_seen_d  = 1'b0;
        second_seen_d = 1'b0;
        text_ended_d  = 1'b0;
        line_len_d    = '0;
      end else if (line_len_q < LenMax) begin
        line_len_d = line_len_q + LenW'(1);
        if (!text_ended_q) begin
          if (rx_byte_i == csvlp_pkg::CharNul) begin
            text_ended_d = 1'b1;
          end else if (rx_byte_i == csvlp_pkg::CharComma) begin
            if (line_stage_q == csvlp_pkg::LineFirstToken) begin
              line_stage_d = csvlp_pkg::LineBeforeSecond;
            end else if (line_stage_q == csvlp_pkg::LineSecondToken) begin
              line_stage_d = csvlp_pkg::LineRest;
            end
          end else if (line_stage_q != csvlp_pkg::LineRest) begin
            if (line_stage_q == csvlp_pkg::LineBeforeFirst) begin
              line_stage_d = csvlp_pkg::LineFirstToken;
              first_seen_d = 1'b1;
            end else if (line_stage_q == csvlp_pkg::LineBeforeSecond) begin
              line_stage_d  = csvlp_pkg::LineSecondToken;
              second_seen_d = 1'b1;
            end
            num_stage_d = feed_stage;
            case (feed_stage)
              csvlp_pkg::NumBlank: begin
                if (!is_blank) begin
                  if (is_sign) begin
                    if (rx_byte_i == csvlp_pkg::CharMinus) begin
                      if (feed_second) status_neg_d = 1'b1;
                      else             sample_neg_d = 1'b1;
                    end
                    num_stage_d = csvlp_pkg::NumDigits;
                  end else if (is_digit) begin
                    if (feed_second) status_acc_d = TW'(digit);
                    else             sample_acc_d = SW'(digit);
                    num_stage_d = csvlp_pkg::NumDigits;
                  end else begin
                    num_stage_d = csvlp_pkg::NumDone;
                  end
                end
              end
              csvlp_pkg::NumDigits: begin
                if (is_digit) begin
                  // acc * 10 + digit, wrapping in the accumulator width
                  if (feed_second) begin
                    status_acc_d = {status_acc_q[TW-4:0], 3'b000} +
                                   {status_acc_q[TW-2:0], 1'b0} + TW'(digit);
                  end else begin
                    sample_acc_d = {sample_acc_q[SW-4:0], 3'b000} +
                                   {sample_acc_q[SW-2:0], 1'b0} + SW'(digit);
                  end
                end else begin
                  num_stage_d = csvlp_pkg::NumDone;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  // FIFO pointers: a pop reads the oldest entry; a push onto a full FIFO
  // advances the read pointer to drop the oldest.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = ptr_inc(wr_ptr_q);
      if (count_q == CntFull) begin
        rd_ptr_d = ptr_inc(rd_ptr_q);
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else if (pop_hit) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
      count_d  = count_q - CntW'(1);
    end
  end

  csvlp_ram #(
    .Width (SW),
    .Depth (FIFO_DEPTH),
    .AddrW (PtrW)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wr_ptr_q),
    .wdata_i (push_val),
    .re_i    (pop_hit),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_stage_q  <= csvlp_pkg::LineBeforeFirst;
      num_stage_q   <= csvlp_pkg::NumBlank;
      sample_acc_q  <= '0;
      status_acc_q  <= '0;
      sample_neg_q  <= 1'b0;
      status_neg_q  <= 1'b0;
      first_seen_q  <= 1'b0;
      second_seen_q <= 1'b0;
      text_ended_q  <= 1'b0;
      line_len_q    <= '0;
      wr_ptr_q      <= '0;
      rd_ptr_q      <= '0;
      count_q       <= '0;
      status_q      <= csvlp_pkg::LinkDisconnected;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      last_sample_q <= '0;
    end else begin
      line_stage_q  <= line_stage_d;
      num_stage_q   <= num_stage_d;
      sample_acc_q  <= sample_acc_d;
      status_acc_q  <= status_acc_d;
      sample_neg_q  <= sample_neg_d;
      status_neg_q  <= status_neg_d;
      first_seen_q  <= first_seen_d;
      second_seen_q <= second_seen_d;
      text_ended_q  <= text_ended_d;
      line_len_q    <= line_len_d;
      wr_ptr_q      <= wr_ptr_d;
      rd_ptr_q      <= rd_ptr_d;
      count_q       <= count_d;
      status_q      <= status_d;
      // Hold the read stage until the output register can take it.
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q   <= 1'b1;
        last_sample_q <= s1_sample;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The RAM read register takes a popped sample as the pop is accepted;
  // that register holds until the next read, which only comes with a new item.
  assign s1_sample = s1_pop_q ? ram_rdata : last_sample_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pop_q    <= pop_hit;
      s1_count_q  <= count_d;
      s1_status_q <= status_d;
    end
    if (s1_move) begin
      out_sample_q <= s1_sample;
      out_count_q  <= s1_count_q;
      out_status_q <= s1_status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = out_sample_q;
  assign sample_count_o = out_count_q;
  assign has_sample_o   = (out_count_q != '0);
  assign link_status_o  = out_status_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("FIFO count exceeds depth");

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((int'(rd_ptr_q) + int'(count_q)) == int'(wr_ptr_q)) ||
    ((int'(rd_ptr_q) + int'(count_q)) == (int'(wr_ptr_q) + int'(FIFO_DEPTH))))
    else $error("FIFO pointers disagree with count");

  a_full_push_keeps_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (count_q == CntFull)) |=> (count_q == CntFull))
    else $error("push onto full FIFO changed the count");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |-> !in_accept)
    else $error("read stage overwritten while stalled");

  a_empty_pop_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_ev && (count_q == '0)) |=> (count_q == '0) && $stable(rd_ptr_q))
    else $error("pop on empty FIFO changed state");

endmodule

/* hdl/csvlp_ram.sv */
// ----------------------------------------------------------------------------
// csvlp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module csvlp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/csv_sample_line_parser_fifo_checker.sv */
// ----------------------------------------------------------------------------
// csv_sample_line_parser_fifo_checker
// Watches both channels of the CSV line parser, predicts and compares.
// ----------------------------------------------------------------------------
// Every accepted input transaction advances a private copy of the parser and
// sample FIFO and queues the result it must produce. Every accepted result is
// compared, field by field, with the oldest queued prediction.
// ----------------------------------------------------------------------------
module csv_sample_line_parser_fifo_checker #(
  parameter int unsigned FIFO_DEPTH = csvlp_pkg::FifoDepthDefault,
  parameter int unsigned LINE_BYTES = csvlp_pkg::LineBytesDefault,
  parameter int unsigned CntW       = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          kind_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [csvlp_pkg::SampleW-1:0] sample_out_i,
  input  logic                          has_sample_i,
  input  logic [1:0]                    link_status_i,
  input  logic [CntW-1:0]               sample_count_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned SW   = csvlp_pkg::SampleW;
  localparam int unsigned TW   = csvlp_pkg::StatusW;

  typedef struct packed {
    logic [SW-1:0]           sample;
    logic                    has_sample;
    csvlp_pkg::link_status_e link;
    logic [CntW-1:0]         count;
  } line_result_t;

  csvlp_pkg::line_stage_e   line_st;
  csvlp_pkg::number_stage_e num_st;
  logic [SW-1:0]            sample_acc;
  logic [TW-1:0]            status_acc;
  logic                     sample_neg;
  logic                     status_neg;
  logic                     first_seen;
  logic                     second_seen;
  logic                     text_done;
  int unsigned              line_len;
  logic [SW-1:0]            ring [FIFO_DEPTH];
  int unsigned              ring_wr;
  int unsigned              ring_rd;
  int unsigned              ring_count;
  logic [SW-1:0]            last_popped;
  csvlp_pkg::link_status_e  link_reg;
  line_result_t             predicted_q [$];

  task automatic clear_line();
    line_st     = csvlp_pkg::LineBeforeFirst;
    num_st      = csvlp_pkg::NumBlank;
    sample_acc  = '0;
    status_acc  = '0;
    sample_neg  = 1'b0;
    status_neg  = 1'b0;
    first_seen  = 1'b0;
    second_seen = 1'b0;
    text_done   = 1'b0;
    line_len    = 0;
  endtask

  // atoi-style scan of one token character
  task automatic scan_char(input logic [7:0] ch, input logic second);
    logic       blank;
    logic       digit;
    logic [7:0] d;
    blank = (ch == csvlp_pkg::CharSpace) || (ch == csvlp_pkg::CharTab) ||
            (ch == csvlp_pkg::CharVt) || (ch == csvlp_pkg::CharFf);
    digit = (ch >= csvlp_pkg::CharZero) && (ch <= csvlp_pkg::CharNine);
    d     = digit ? ch - csvlp_pkg::CharZero : 8'd0;
    case (num_st)
      csvlp_pkg::NumBlank: begin
        if (!blank) begin
          if (ch == csvlp_pkg::CharPlus || ch == csvlp_pkg::CharMinus) begin
            if (ch == csvlp_pkg::CharMinus) begin
              if (second) status_neg = 1'b1;
              else        sample_neg = 1'b1;
            end
            num_st = csvlp_pkg::NumDigits;
          end else if (digit) begin
            if (second) status_acc = d;
            else        sample_acc = {8'h00, d};
            num_st = csvlp_pkg::NumDigits;
          end else begin
            num_st = csvlp_pkg::NumDone;
          end
        end
      end
      csvlp_pkg::NumDigits: begin
        if (digit) begin
          if (second) status_acc = status_acc * 8'd10 + d;
          else        sample_acc = sample_acc * 16'd10 + {8'h00, d};
        end else begin
          num_st = csvlp_pkg::NumDone;
        end
      end
      default: ;
    endcase
  endtask

  task automatic advance_parser(input logic kind, input logic [7:0] ch);
    line_result_t  res;
    logic [SW-1:0] s;
    logic [TW-1:0] t;
    if (kind == csvlp_pkg::KindPop) begin
      if (ring_count != 0) begin
        last_popped = ring[PtrW'(ring_rd)];
        ring_rd     = (ring_rd + 1) % FIFO_DEPTH;
        ring_count--;
      end
    end else if (ch == csvlp_pkg::CharCr || ch == csvlp_pkg::CharLf) begin
      if (line_len != 0 && first_seen) begin
        s = sample_neg ? (16'd0 - sample_acc) : sample_acc;
        if (second_seen) begin
          t = status_neg ? (8'd0 - status_acc) : status_acc;
          if (t == 8'd0)      link_reg = csvlp_pkg::LinkConnected;
          else if (t == 8'd1) link_reg = csvlp_pkg::LinkCheckLeads;
          else                link_reg = csvlp_pkg::LinkDisconnected;
        end
        // full FIFO: drop the oldest entry
        if (ring_count >= FIFO_DEPTH) begin
          ring_rd = (ring_rd + 1) % FIFO_DEPTH;
          ring_count--;
        end
        ring[PtrW'(ring_wr)] = s;
        ring_wr              = (ring_wr + 1) % FIFO_DEPTH;
        ring_count++;
      end
      clear_line();
    end else if (line_len < LINE_BYTES - 1) begin
      line_len++;
      if (!text_done) begin
        if (ch == csvlp_pkg::CharNul) begin
          text_done = 1'b1;
        end else if (ch == csvlp_pkg::CharComma) begin
          if (line_st == csvlp_pkg::LineFirstToken)       line_st = csvlp_pkg::LineBeforeSecond;
          else if (line_st == csvlp_pkg::LineSecondToken) line_st = csvlp_pkg::LineRest;
        end else begin
          case (line_st)
            csvlp_pkg::LineBeforeFirst: begin
              line_st    = csvlp_pkg::LineFirstToken;
              first_seen = 1'b1;
              num_st     = csvlp_pkg::NumBlank;
              scan_char(ch, 1'b0);
            end
            csvlp_pkg::LineFirstToken: scan_char(ch, 1'b0);
            csvlp_pkg::LineBeforeSecond: begin
              line_st     = csvlp_pkg::LineSecondToken;
              second_seen = 1'b1;
              num_st      = csvlp_pkg::NumBlank;
              scan_char(ch, 1'b1);
            end
            csvlp_pkg::LineSecondToken: scan_char(ch, 1'b1);
            default: ;
          endcase
        end
      end
    end
    res.sample     = last_popped;
    res.has_sample = (ring_count != 0);
    res.link       = link_reg;
    res.count      = ring_count[CntW-1:0];
    predicted_q.push_back(res);
  endtask

  task automatic check_field(input string field, input int unsigned predicted,
                             input int unsigned seen);
    if (predicted != seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, predicted, seen);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_result_t res;
    if (!rst_ni) begin
      clear_line();
      ring_wr      = 0;
      ring_rd      = 0;
      ring_count   = 0;
      last_popped  = '0;
      link_reg     = csvlp_pkg::LinkDisconnected;
      predicted_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        advance_parser(kind_i, rx_byte_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual sample %0d count %0d",
                   $time, sample_out_i, sample_count_i);
          fail_count_o++;
        end else begin
          res = predicted_q.pop_front();
          check_field("sample_out", 32'(res.sample), 32'(sample_out_i));
          check_field("has_sample", 32'(res.has_sample), 32'(has_sample_i));
          check_field("link_status", 32'(res.link), 32'(link_status_i));
          check_field("sample_count", 32'(res.count), 32'(sample_count_i));
        end
      end
      pending_o = predicted_q.size();
    end
  end

endmodule

/* tb/csv_sample_line_parser_fifo_test.sv */
// ----------------------------------------------------------------------------
// csv_sample_line_parser_fifo_test
// Stimulus and verdict for the CSV sample line parser with sample FIFO.
// ----------------------------------------------------------------------------
// Feeds a short directed sequence of text lines and pops, then random lines
// (mostly well formed, some noise, long lines and pop bursts) under four
// idling phases. A checker beside the block predicts and compares every
// result; this module reports the verdict.
// ----------------------------------------------------------------------------
module csv_sample_line_parser_fifo_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CntW          = $clog2(csvlp_pkg::FifoDepthDefault + 1);
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 250;
  localparam int unsigned DrainCycles   = 8;

  logic                          clk_i    = 1'b0;
  logic                          rst_ni   = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          kind     = csvlp_pkg::KindByte;
  logic [7:0]                    rx_byte  = 8'h00;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [csvlp_pkg::SampleW-1:0] sample_out;
  logic                          has_sample;
  logic [1:0]                    link_status;
  logic [CntW-1:0]               sample_count;

  int          fail_count;
  int          pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  int unsigned quiet_cycles   = 0;

  csv_sample_line_parser_fifo DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .sample_out_o   (sample_out),
    .has_sample_o   (has_sample),
    .link_status_o  (link_status),
    .sample_count_o (sample_count)
  );

  csv_sample_line_parser_fifo_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .kind_i         (kind),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .sample_out_i   (sample_out),
    .has_sample_i   (has_sample),
    .link_status_i  (link_status),
    .sample_count_i (sample_count),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // 20 ns clock: 10 ns high, 10 ns low
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stall the result channel at the rate of the current phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Count cycles with no transaction on either channel; end the run if the
  // block stops moving.
  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Offer one input transaction, idling first at the phase rate, and hold it
  // until accepted. Valid stays high between back-to-back transactions.
  task automatic send_item(input logic k, input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind     <= k;
    rx_byte  <= ch;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(csvlp_pkg::KindByte, s[i]);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(3))
      0:       return csvlp_pkg::CharSpace;
      1:       return csvlp_pkg::CharTab;
      2:       return csvlp_pkg::CharVt;
      default: return csvlp_pkg::CharFf;
    endcase
  endfunction

  function automatic logic [7:0] line_end_char();
    return $urandom_range(1) ? csvlp_pkg::CharCr : csvlp_pkg::CharLf;
  endfunction

  function automatic logic [7:0] sign_char();
    return $urandom_range(1) ? csvlp_pkg::CharMinus : csvlp_pkg::CharPlus;
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'(csvlp_pkg::CharZero + $urandom_range(9));
  endfunction

  // Build a "sample,status" line with random content: leading blanks, an
  // optional sign, repeated commas, overflowing values, a trailing third
  // token or an embedded NUL now and then.
  task automatic send_csv_line();
    int unsigned sel;
    int unsigned value;
    repeat ($urandom_range(2)) send_item(csvlp_pkg::KindByte, blank_char());
    if ($urandom_range(4) == 0) send_item(csvlp_pkg::KindByte, sign_char());
    sel = $urandom_range(9);
    if (sel == 0)      value = 0;
    else if (sel == 1) value = 65535;
    else if (sel == 2) value = $urandom_range(999999, 65536);
    else               value = $urandom_range(65535);
    send_text($sformatf("%0d", value));
    if ($urandom_range(9) != 0) begin
      repeat ($urandom_range(2, 1)) send_item(csvlp_pkg::KindByte, csvlp_pkg::CharComma);
      if ($urandom_range(3) == 0) send_item(csvlp_pkg::KindByte, blank_char());
      if ($urandom_range(4) == 0) send_item(csvlp_pkg::KindByte, sign_char());
      value = ($urandom_range(3) != 0) ? $urandom_range(2) : $urandom_range(999);
      send_text($sformatf("%0d", value));
      if ($urandom_range(7) == 0) send_text(",9");
    end
    if ($urandom_range(15) == 0) begin
      send_item(csvlp_pkg::KindByte, csvlp_pkg::CharNul);
      send_item(csvlp_pkg::KindByte, digit_char());
    end
    send_item(csvlp_pkg::KindByte, line_end_char());
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned action;

    // Hold reset, then release it at a clock edge.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    // Pop on an empty FIFO: returns the reset sample and changes nothing.
    send_item(csvlp_pkg::KindPop, 8'hFF);
    // Leading blank and plus sign, TAB and minus before the status: 7, -255.
    send_item(csvlp_pkg::KindByte, csvlp_pkg::CharSpace);
    send_item(csvlp_pkg::KindByte, csvlp_pkg::CharPlus);
    send_text("7,");
    send_item(csvlp_pkg::KindByte, csvlp_pkg::CharTab);
    send_text("-255");
    send_item(csvlp_pkg::KindByte, csvlp_pkg::CharCr);
    // Sample overflows 16 bits; status 0 connects.
    send_text("99999,0");
    send_item(csvlp_pkg::KindByte, csvlp_pkg::CharLf);
    // Only a comma: no first token, nothing pushed.
    send_text(",");
    send_item(csvlp_pkg::KindByte, csvlp_pkg::CharLf);
    // Token with no digits counts as zero.
    send_text("x");
    send_item(csvlp_pkg::KindByte, csvlp_pkg::CharCr);
    // NUL ends the text before any token.
    send_item(csvlp_pkg::KindByte, csvlp_pkg::CharNul);
    send_text("5");
    send_item(csvlp_pkg::KindByte, csvlp_pkg::CharLf);
    // Empty line does nothing.
    send_item(csvlp_pkg::KindByte, csvlp_pkg::CharCr);
    send_item(csvlp_pkg::KindPop, 8'h00);
    send_item(csvlp_pkg::KindPop, 8'h7F);

    // Random part in four idling phases: none, sender idle, receiver stall,
    // both lightly.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 51; end
        default: begin send_idle_pct = 7; recv_stall_pct <= 7; end
      endcase
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        action = $urandom_range(99);
        if (action < 55) begin
          send_csv_line();
        end else if (action < 67) begin
          // short line, quick push: fills the FIFO toward overflow
          send_text($sformatf("%0d", $urandom_range(9)));
          send_item(csvlp_pkg::KindByte, line_end_char());
        end else if (action < 75) begin
          // noise: any kind, any byte
          repeat ($urandom_range(8, 1)) begin
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
          end
          send_item(csvlp_pkg::KindByte, line_end_char());
        end else if (action < 79) begin
          // long line: bytes past the line limit are dropped
          repeat ($urandom_range(80, 60)) begin
            if ($urandom_range(7) == 0) send_item(csvlp_pkg::KindByte, csvlp_pkg::CharComma);
            else                        send_item(csvlp_pkg::KindByte, digit_char());
          end
          send_item(csvlp_pkg::KindByte, line_end_char());
        end else if (action < 81) begin
          // drain past empty to hit pops on an empty FIFO
          repeat ($urandom_range(70, 60)) begin
            send_item(csvlp_pkg::KindPop, 8'($urandom_range(255)));
          end
        end else begin
          repeat ($urandom_range(4, 1)) send_item(csvlp_pkg::KindPop, 8'($urandom_range(255)));
        end
      end
    end
    in_valid <= 1'b0;

    // Let the last predictions drain, then keep watching for strays.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/csvlp_pkg.sv
hdl/csvlp_ram.sv
hdl/csv_sample_line_parser_fifo.sv
tb/csv_sample_line_parser_fifo_checker.sv
tb/csv_sample_line_parser_fifo_test.sv
